// ===== design/usrp_pkg.sv =====
// Shared types, character codes and field codes of the UPS status reply parser.
package usrp_pkg;

  localparam int VALUE_CHARS_DEF = 31;

  // Classified byte queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] LC_A     = 8'h61;
  localparam logic [7:0] LC_Z     = 8'h7A;

  // Field codes; codes I..R double as the index into the value store
  localparam logic [3:0] CODE_I     = 4'd0;
  localparam logic [3:0] CODE_O     = 4'd1;
  localparam logic [3:0] CODE_L     = 4'd2;
  localparam logic [3:0] CODE_B     = 4'd3;
  localparam logic [3:0] CODE_V     = 4'd4;
  localparam logic [3:0] CODE_T     = 4'd5;
  localparam logic [3:0] CODE_F     = 4'd6;
  localparam logic [3:0] CODE_H     = 4'd7;
  localparam logic [3:0] CODE_R     = 4'd8;
  localparam logic [3:0] CODE_S     = 4'd9;
  localparam logic [3:0] CODE_OTHER = 4'd10;
  localparam logic [3:0] CODE_NONE  = 4'd15;
  localparam int         NUM_VALUES = 9;

  // Status flag byte bits
  localparam logic [7:0] FLAG_ON_BATT  = 8'h40;
  localparam logic [7:0] FLAG_LOW_BATT = 8'h20;
  localparam logic [7:0] FLAG_NO_JUDGE = 8'h48;
  localparam logic [7:0] FLAG_TEST     = 8'h08;

  localparam logic [15:0] SAT16      = 16'hFFFF;
  localparam logic [15:0] TEMP_LIMIT = 16'd9999;
  localparam logic [5:0]  KNOWN_MAX  = 6'd63;
  localparam logic [5:0]  OK_MIN     = 6'd3;

  typedef enum logic [1:0] {
    TK_IGNORE,
    TK_LETTER,
    TK_DATA
  } tok_kind_t;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_SIGN_POS,
    CC_SIGN_NEG,
    CC_DIGIT,
    CC_DOT,
    CC_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    NP_START,
    NP_INT,
    NP_FRAC,
    NP_DONE
  } num_phase_t;

  typedef struct packed {
    logic        last;
    logic        hdr_good;
    tok_kind_t   kind;
    logic [3:0]  code;
    logic [7:0]  data;
    char_class_t cls;
    logic [3:0]  digit;
  } token_t;

endpackage

// ===== design/usrp_front.sv =====
// Front end: header check and byte classification into tokens.
module usrp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      rx_byte,
  input  logic            end_of_reply,
  input  logic            q_full,
  output logic            push_valid,
  output usrp_pkg::token_t tok
);
  import usrp_pkg::*;

  logic at_first_byte;
  logic header_good;
  logic hdr_now;
  logic accept;

  function automatic logic [3:0] code_of(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      "I":     c = CODE_I;
      "O":     c = CODE_O;
      "L":     c = CODE_L;
      "B":     c = CODE_B;
      "V":     c = CODE_V;
      "T":     c = CODE_T;
      "F":     c = CODE_F;
      "H":     c = CODE_H;
      "R":     c = CODE_R;
      "S":     c = CODE_S;
      default: c = CODE_OTHER;
    endcase
    return c;
  endfunction

  assign accept     = in_valid && !q_full;
  assign push_valid = in_valid;

  always_comb begin
    hdr_now   = header_good;
    tok.kind  = TK_IGNORE;
    if (at_first_byte) begin
      hdr_now = (rx_byte == CH_HASH);
    end else if (header_good) begin
      if ((rx_byte | CASE_BIT) inside {[LC_A:LC_Z]}) begin
        tok.kind = TK_LETTER;
      end else begin
        tok.kind = TK_DATA;
      end
    end
    tok.last     = end_of_reply;
    tok.hdr_good = hdr_now;
    tok.code     = code_of(rx_byte);
    tok.data     = rx_byte;
    tok.digit    = 4'(rx_byte - CH_ZERO);
    if (rx_byte inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
      tok.cls = CC_SPACE;
    end else if (rx_byte == CH_PLUS) begin
      tok.cls = CC_SIGN_POS;
    end else if (rx_byte == CH_MINUS) begin
      tok.cls = CC_SIGN_NEG;
    end else if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
      tok.cls = CC_DIGIT;
    end else if (rx_byte == CH_DOT) begin
      tok.cls = CC_DOT;
    end else begin
      tok.cls = CC_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_byte <= 1'b1;
      header_good   <= 1'b0;
    end else if (accept) begin
      if (end_of_reply) begin
        at_first_byte <= 1'b1;
        header_good   <= 1'b0;
      end else begin
        at_first_byte <= 1'b0;
        header_good   <= hdr_now;
      end
    end
  end

endmodule

// ===== design/usrp_queue.sv =====
// Token queue between front end and field engine.
module usrp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  usrp_pkg::token_t push_data,
  output logic             full,
  output logic             pop_valid,
  output usrp_pkg::token_t pop_data,
  input  logic             pop_take
);
  import usrp_pkg::*;

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_take;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/usrp_back.sv =====
// Field engine: number parsing, field store, reply finish and result register.
module usrp_back #(
  parameter int VALUE_CHARS = usrp_pkg::VALUE_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  usrp_pkg::token_t  pop_data,
  output logic              pop_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              parse_ok,
  output logic [15:0]       in_volt_tenths,
  output logic [15:0]       out_volt_tenths,
  output logic [15:0]       load_pct,
  output logic [15:0]       charge_pct,
  output logic [15:0]       batt_volt_tenths,
  output logic signed [14:0] temperature,
  output logic [15:0]       in_freq_tenths,
  output logic [15:0]       out_freq_tenths,
  output logic [15:0]       runtime_min,
  output logic [3:0]        present_mask,
  output logic [5:0]        power_state
);
  import usrp_pkg::*;

  localparam int LEN_W = $clog2(VALUE_CHARS + 1);

  // Parser state
  logic [3:0]       open_code, open_code_next;
  logic             seen_input_freq, seen_input_freq_next;
  logic [15:0]      int_accum, int_accum_next;
  logic [3:0]       frac_digit, frac_digit_next;
  num_phase_t       number_phase, number_phase_next;
  logic             negative_value, negative_value_next;
  logic [LEN_W-1:0] value_length, value_length_next;
  logic [7:0]       flag_byte, flag_byte_next;
  logic [5:0]       known_count, known_count_next;
  logic [15:0]      field_values [NUM_VALUES];
  logic [15:0]      field_values_next [NUM_VALUES];
  logic [3:0]       presence_bits, presence_bits_next;
  logic             fin_pend, fin_pend_next;
  logic             fin_hdr, fin_hdr_next;

  // Finished reply snapshot
  logic             snap_valid, snap_valid_next;
  logic             snap_ok, snap_ok_next;
  logic [15:0]      snap_fv [NUM_VALUES];
  logic [15:0]      snap_fv_next [NUM_VALUES];
  logic [3:0]       snap_pres, snap_pres_next;
  logic [7:0]       snap_flag, snap_flag_next;

  // Field close values
  logic [19:0]      tenths_wide;
  logic [15:0]      tenths_val;
  logic [15:0]      int_val;
  logic [15:0]      temp_mag;
  logic [15:0]      temp_val;
  logic [15:0]      fv_closed [NUM_VALUES];
  logic [5:0]       known_closed;
  logic [3:0]       pres_closed;
  logic             seen_closed;
  logic [7:0]       flag_closed;
  logic [19:0]      accum_wide;

  logic             take;
  logic             fin_do;
  logic             load;
  logic             snap_free;

  // Result stage
  logic [20:0]      iv_x2, ov_x2, ov_x20, iv_x19, iv_x21, iv_x3;
  logic [5:0]       ps;

  assign pop_take  = !fin_pend;
  assign take      = pop_valid && !fin_pend;
  assign load      = snap_valid && (!out_valid || !out_stall);
  assign snap_free = !snap_valid || load;
  assign fin_do    = fin_pend && snap_free;

  // Value of the open field when it closes
  always_comb begin
    tenths_wide = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1) + 20'(frac_digit);
    if (negative_value) begin
      tenths_val = '0;
    end else if (tenths_wide > 20'(SAT16)) begin
      tenths_val = SAT16;
    end else begin
      tenths_val = tenths_wide[15:0];
    end
    int_val  = negative_value ? '0 : int_accum;
    temp_mag = (int_accum > TEMP_LIMIT) ? TEMP_LIMIT : int_accum;
    temp_val = negative_value ? 16'(16'd0 - temp_mag) : temp_mag;

    fv_closed    = field_values;
    known_closed = known_count;
    pres_closed  = presence_bits;
    seen_closed  = seen_input_freq;
    flag_closed  = flag_byte;
    if (open_code <= CODE_S) begin
      if (known_count < KNOWN_MAX) begin
        known_closed = known_count + 1'b1;
      end
      case (open_code)
        CODE_I, CODE_O, CODE_V, CODE_F, CODE_H: fv_closed[open_code] = tenths_val;
        CODE_L, CODE_B, CODE_R:                 fv_closed[open_code] = int_val;
        CODE_T:                                 fv_closed[open_code] = temp_val;
        default: begin
          if (value_length == '0) begin
            flag_closed = '0;
          end
        end
      endcase
      if (open_code == CODE_T) pres_closed[0] = 1'b1;
      if (open_code == CODE_V) pres_closed[1] = 1'b1;
      if (open_code == CODE_H) pres_closed[2] = 1'b1;
      if (open_code == CODE_R) pres_closed[3] = 1'b1;
      if (open_code == CODE_F) seen_closed    = 1'b1;
    end
  end

  // Next state of the engine
  always_comb begin
    open_code_next       = open_code;
    seen_input_freq_next = seen_input_freq;
    int_accum_next       = int_accum;
    frac_digit_next      = frac_digit;
    number_phase_next    = number_phase;
    negative_value_next  = negative_value;
    value_length_next    = value_length;
    flag_byte_next       = flag_byte;
    known_count_next     = known_count;
    field_values_next    = field_values;
    presence_bits_next   = presence_bits;
    fin_pend_next        = fin_pend;
    fin_hdr_next         = fin_hdr;
    snap_valid_next      = snap_valid && !load;
    snap_ok_next         = snap_ok;
    snap_fv_next         = snap_fv;
    snap_pres_next       = snap_pres;
    snap_flag_next       = snap_flag;

    accum_wide = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1) + 20'(pop_data.digit);

    if (fin_do) begin
      // Close the last field, hand the reply over, clear for the next one
      snap_valid_next      = 1'b1;
      snap_ok_next         = fin_hdr && (known_closed >= OK_MIN);
      snap_fv_next         = fv_closed;
      snap_pres_next       = pres_closed;
      snap_flag_next       = flag_closed;
      fin_pend_next        = 1'b0;
      fin_hdr_next         = 1'b0;
      open_code_next       = CODE_NONE;
      seen_input_freq_next = 1'b0;
      int_accum_next       = '0;
      frac_digit_next      = '0;
      number_phase_next    = NP_START;
      negative_value_next  = 1'b0;
      value_length_next    = '0;
      flag_byte_next       = '0;
      known_count_next     = '0;
      presence_bits_next   = '0;
      for (int k = 0; k < NUM_VALUES; k++) begin
        field_values_next[k] = '0;
      end
    end else if (take) begin
      case (pop_data.kind)
        TK_LETTER: begin
          field_values_next    = fv_closed;
          known_count_next     = known_closed;
          presence_bits_next   = pres_closed;
          seen_input_freq_next = seen_closed;
          flag_byte_next       = flag_closed;
          open_code_next       = (pop_data.code == CODE_F && seen_closed) ? CODE_H
                                                                          : pop_data.code;
          int_accum_next       = '0;
          frac_digit_next      = '0;
          number_phase_next    = NP_START;
          negative_value_next  = 1'b0;
          value_length_next    = '0;
        end
        TK_DATA: begin
          if (value_length < LEN_W'(VALUE_CHARS)) begin
            if (open_code == CODE_S && value_length == '0) begin
              flag_byte_next = pop_data.data;
            end
            value_length_next = value_length + 1'b1;
            if (number_phase == NP_START && pop_data.cls == CC_SPACE) begin
              number_phase_next = NP_START;
            end else if (number_phase == NP_START &&
                         (pop_data.cls == CC_SIGN_POS || pop_data.cls == CC_SIGN_NEG)) begin
              negative_value_next = (pop_data.cls == CC_SIGN_NEG);
              number_phase_next   = NP_INT;
            end else if ((number_phase == NP_START || number_phase == NP_INT) &&
                         pop_data.cls == CC_DIGIT) begin
              int_accum_next    = (accum_wide > 20'(SAT16)) ? SAT16 : accum_wide[15:0];
              number_phase_next = NP_INT;
            end else if ((number_phase == NP_START || number_phase == NP_INT) &&
                         pop_data.cls == CC_DOT) begin
              number_phase_next = NP_FRAC;
            end else if (number_phase == NP_FRAC && pop_data.cls == CC_DIGIT) begin
              frac_digit_next   = pop_data.digit;
              number_phase_next = NP_DONE;
            end else begin
              number_phase_next = NP_DONE;
            end
          end
        end
        default: begin
        end
      endcase
      if (pop_data.last) begin
        fin_pend_next = 1'b1;
        fin_hdr_next  = pop_data.hdr_good;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_code       <= CODE_NONE;
      seen_input_freq <= 1'b0;
      int_accum       <= '0;
      frac_digit      <= '0;
      number_phase    <= NP_START;
      negative_value  <= 1'b0;
      value_length    <= '0;
      flag_byte       <= '0;
      known_count     <= '0;
      field_values    <= '{default: '0};
      presence_bits   <= '0;
      fin_pend        <= 1'b0;
      fin_hdr         <= 1'b0;
      snap_valid      <= 1'b0;
    end else begin
      open_code       <= open_code_next;
      seen_input_freq <= seen_input_freq_next;
      int_accum       <= int_accum_next;
      frac_digit      <= frac_digit_next;
      number_phase    <= number_phase_next;
      negative_value  <= negative_value_next;
      value_length    <= value_length_next;
      flag_byte       <= flag_byte_next;
      known_count     <= known_count_next;
      field_values    <= field_values_next;
      presence_bits   <= presence_bits_next;
      fin_pend        <= fin_pend_next;
      fin_hdr         <= fin_hdr_next;
      snap_valid      <= snap_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    snap_ok   <= snap_ok_next;
    snap_fv   <= snap_fv_next;
    snap_pres <= snap_pres_next;
    snap_flag <= snap_flag_next;
  end

  // Power state: trim below 0.95, boost below 1.5 above 1.05, nothing under 0.5
  always_comb begin
    iv_x2  = {4'd0, snap_fv[CODE_I], 1'b0};
    ov_x2  = {4'd0, snap_fv[CODE_O], 1'b0};
    ov_x20 = ({5'd0, snap_fv[CODE_O]} << 4) + ({5'd0, snap_fv[CODE_O]} << 2);
    iv_x19 = ({5'd0, snap_fv[CODE_I]} << 4) + ({5'd0, snap_fv[CODE_I]} << 1)
           + {5'd0, snap_fv[CODE_I]};
    iv_x21 = ({5'd0, snap_fv[CODE_I]} << 4) + ({5'd0, snap_fv[CODE_I]} << 2)
           + {5'd0, snap_fv[CODE_I]};
    iv_x3  = iv_x2 + {5'd0, snap_fv[CODE_I]};
    ps = '0;
    ps[0] = (snap_flag & FLAG_ON_BATT) != '0;
    ps[1] = (snap_flag & FLAG_LOW_BATT) != '0;
    if ((snap_flag & FLAG_NO_JUDGE) == '0) begin
      if (ov_x2 < {5'd0, snap_fv[CODE_I]}) begin
        ps[2] = 1'b0;
      end else if (ov_x20 < iv_x19) begin
        ps[2] = 1'b1;
      end else if (ov_x20 < iv_x21) begin
        ps[3] = 1'b0;
      end else if (ov_x2 < iv_x3) begin
        ps[3] = 1'b1;
      end
    end
    ps[4] = (snap_flag & FLAG_TEST) != '0;
    ps[5] = (snap_flag == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      parse_ok         <= snap_ok;
      in_volt_tenths   <= snap_ok ? snap_fv[CODE_I] : '0;
      out_volt_tenths  <= snap_ok ? snap_fv[CODE_O] : '0;
      load_pct         <= snap_ok ? snap_fv[CODE_L] : '0;
      charge_pct       <= snap_ok ? snap_fv[CODE_B] : '0;
      batt_volt_tenths <= snap_ok ? snap_fv[CODE_V] : '0;
      temperature      <= snap_ok ? snap_fv[CODE_T][14:0] : '0;
      in_freq_tenths   <= snap_ok ? snap_fv[CODE_F] : '0;
      out_freq_tenths  <= snap_ok ? snap_fv[CODE_H] : '0;
      runtime_min      <= snap_ok ? snap_fv[CODE_R] : '0;
      present_mask     <= snap_ok ? snap_pres : '0;
      power_state      <= snap_ok ? ps : '0;
    end
  end

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    fin_pend && !snap_free |=> fin_pend)
    else $error("finish request dropped while snapshot busy");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    fin_do |=> snap_valid && open_code == CODE_NONE && known_count == '0)
    else $error("reply finish did not hand over and clear");

  a_snap_holds: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !load |=> snap_valid && $stable(snap_ok))
    else $error("snapshot lost before result register took it");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !load |=> !out_valid)
    else $error("result shown twice");

endmodule

// ===== design/ups_status_reply_parser.sv =====
// Top level of the UPS status reply parser: front end, token queue, field engine.
//
// Usage:
//   Input channel (in_valid / in_stall): one reply byte per transfer, rx_byte, with
//   end_of_reply high on the final byte. The reply must open with '#'.
//   Output channel (out_valid / out_stall): one result per reply, carrying parse_ok,
//   the field values, present_mask and power_state. All fields read 0 on a failed parse.
//   Throughput: one byte per cycle while in_stall is low. After the final byte of a
//   reply the field engine takes no token until it has closed the open field and
//   handed the reply over. The final byte passes the queue write, the engine, the
//   finish/snapshot and the result register before the result shows on out_valid.
//   A four-entry token queue parts the front end from the engine; in_stall rises
//   only when that queue is full. While the receiver holds out_stall, one finished
//   reply waits in the result register and a second in the snapshot; bytes keep
//   flowing until the queue fills behind a third finished reply.
//   Reset (rst, synchronous): empties the queue, drops any partial reply and any
//   waiting result, and expects the first byte of a new reply.
module ups_status_reply_parser #(
  parameter int VALUE_CHARS = usrp_pkg::VALUE_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              end_of_reply,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              parse_ok,
  output logic [15:0]       in_volt_tenths,
  output logic [15:0]       out_volt_tenths,
  output logic [15:0]       load_pct,
  output logic [15:0]       charge_pct,
  output logic [15:0]       batt_volt_tenths,
  output logic signed [14:0] temperature,
  output logic [15:0]       in_freq_tenths,
  output logic [15:0]       out_freq_tenths,
  output logic [15:0]       runtime_min,
  output logic [3:0]        present_mask,
  output logic [5:0]        power_state
);
  import usrp_pkg::*;

  // Front end to queue
  logic   push_valid;
  token_t push_tok;
  logic   q_full;

  // Queue to engine
  logic   pop_valid;
  token_t pop_tok;
  logic   pop_take;

  // Stall the sender only on a full queue
  assign in_stall = q_full;

  usrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .rx_byte      (rx_byte),
    .end_of_reply (end_of_reply),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .tok          (push_tok)
  );

  usrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_tok),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_data   (pop_tok),
    .pop_take   (pop_take)
  );

  // Engine parses values, finishes replies and owns the result register
  usrp_back #(
    .VALUE_CHARS (VALUE_CHARS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_data         (pop_tok),
    .pop_take         (pop_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parse_ok         (parse_ok),
    .in_volt_tenths   (in_volt_tenths),
    .out_volt_tenths  (out_volt_tenths),
    .load_pct         (load_pct),
    .charge_pct       (charge_pct),
    .batt_volt_tenths (batt_volt_tenths),
    .temperature      (temperature),
    .in_freq_tenths   (in_freq_tenths),
    .out_freq_tenths  (out_freq_tenths),
    .runtime_min      (runtime_min),
    .present_mask     (present_mask),
    .power_state      (power_state)
  );

endmodule

// ===== tb/ups_reply_checker.sv =====
// Reply checker: predicts the result of each reply from the byte transfers and compares.
`timescale 1ns / 100ps
module ups_reply_checker #(
  parameter int VALUE_CHARS = usrp_pkg::VALUE_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              end_of_reply,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              parse_ok,
  input  logic [15:0]       in_volt_tenths,
  input  logic [15:0]       out_volt_tenths,
  input  logic [15:0]       load_pct,
  input  logic [15:0]       charge_pct,
  input  logic [15:0]       batt_volt_tenths,
  input  logic signed [14:0] temperature,
  input  logic [15:0]       in_freq_tenths,
  input  logic [15:0]       out_freq_tenths,
  input  logic [15:0]       runtime_min,
  input  logic [3:0]        present_mask,
  input  logic [5:0]        power_state,
  output int                errors,
  output int                awaited
);
  import usrp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [15:0] in_volt;
    logic [15:0] out_volt;
    logic [15:0] load;
    logic [15:0] charge;
    logic [15:0] batt_volt;
    logic [14:0] temp;
    logic [15:0] in_freq;
    logic [15:0] out_freq;
    logic [15:0] runtime;
    logic [3:0]  mask;
    logic [5:0]  pwr;
  } status_result_t;

  status_result_t replies_due[$];
  int             err_count = 0;

  // parser state, mirrored from the byte stream
  logic        at_start;
  logic        hdr_ok;
  logic [3:0]  field_code;
  logic        saw_in_freq;
  logic [15:0] accum;
  logic [3:0]  frac;
  num_phase_t  phase;
  logic        neg;
  int          vlen;
  logic [7:0]  flag;
  logic [5:0]  known;
  logic [15:0] vals [NUM_VALUES];
  logic [3:0]  seen;

  function automatic void clear_parser();
    at_start    = 1'b1;
    hdr_ok      = 1'b0;
    field_code  = CODE_NONE;
    saw_in_freq = 1'b0;
    accum       = '0;
    frac        = '0;
    phase       = NP_START;
    neg         = 1'b0;
    vlen        = 0;
    flag        = '0;
    known       = '0;
    seen        = '0;
    foreach (vals[k]) vals[k] = '0;
  endfunction

  function automatic logic [15:0] tenths_of_value();
    logic [31:0] t;
    t = 32'(accum) * 32'd10 + 32'(frac);
    if (neg) return '0;
    return (t > 32'(SAT16)) ? SAT16 : t[15:0];
  endfunction

  function automatic void close_field();
    logic [15:0] mag;
    if (field_code > CODE_S) return;
    if (known < KNOWN_MAX) known++;
    case (field_code)
      CODE_I, CODE_O, CODE_V, CODE_F, CODE_H: vals[field_code] = tenths_of_value();
      CODE_L, CODE_B, CODE_R: vals[field_code] = neg ? '0 : accum;
      CODE_T: begin
        mag = (accum > TEMP_LIMIT) ? TEMP_LIMIT : accum;
        vals[CODE_T] = neg ? 16'(16'd0 - mag) : mag;
      end
      default: begin
        // empty status field drops any flag byte from an earlier one
        if (vlen == 0) flag = '0;
      end
    endcase
    if (field_code == CODE_T) seen[0] = 1'b1;
    if (field_code == CODE_V) seen[1] = 1'b1;
    if (field_code == CODE_H) seen[2] = 1'b1;
    if (field_code == CODE_R) seen[3] = 1'b1;
    if (field_code == CODE_F) saw_in_freq = 1'b1;
  endfunction

  function automatic void open_field(logic [7:0] b);
    logic [3:0] c;
    case (b)
      "I":     c = CODE_I;
      "O":     c = CODE_O;
      "L":     c = CODE_L;
      "B":     c = CODE_B;
      "V":     c = CODE_V;
      "T":     c = CODE_T;
      "F":     c = CODE_F;
      "H":     c = CODE_H;
      "R":     c = CODE_R;
      "S":     c = CODE_S;
      default: c = CODE_OTHER;
    endcase
    if (c == CODE_F && saw_in_freq) c = CODE_H;
    field_code = c;
    accum      = '0;
    frac       = '0;
    phase      = NP_START;
    neg        = 1'b0;
    vlen       = 0;
  endfunction

  function automatic void feed_value(logic [7:0] b);
    logic        is_digit;
    logic        is_space;
    logic [31:0] v;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    if (vlen >= VALUE_CHARS) return;
    if (field_code == CODE_S && vlen == 0) flag = b;
    vlen++;
    if (phase == NP_START && is_space) return;
    if (phase == NP_START && (b == CH_PLUS || b == CH_MINUS)) begin
      neg   = (b == CH_MINUS);
      phase = NP_INT;
      return;
    end
    if (phase <= NP_INT && is_digit) begin
      v     = 32'(accum) * 32'd10 + 32'(b - CH_ZERO);
      accum = (v > 32'(SAT16)) ? SAT16 : v[15:0];
      phase = NP_INT;
      return;
    end
    if (phase <= NP_INT && b == CH_DOT) begin
      phase = NP_FRAC;
      return;
    end
    if (phase == NP_FRAC && is_digit) begin
      frac  = 4'(b - CH_ZERO);
      phase = NP_DONE;
      return;
    end
    phase = NP_DONE;
  endfunction

  function automatic status_result_t finish_reply();
    status_result_t r;
    logic [31:0]    iv;
    logic [31:0]    ov;
    logic [5:0]     ps;
    if (hdr_ok) close_field();
    r = '0;
    if (hdr_ok && known >= OK_MIN) begin
      iv = 32'(vals[CODE_I]);
      ov = 32'(vals[CODE_O]);
      ps = '0;
      if ((flag & FLAG_ON_BATT) != 0) ps[0] = 1'b1;
      if ((flag & FLAG_LOW_BATT) != 0) ps[1] = 1'b1;
      if ((flag & FLAG_NO_JUDGE) == 0 && 2 * ov >= iv) begin
        if (20 * ov < 19 * iv) ps[2] = 1'b1;
        else if (20 * ov >= 21 * iv && 2 * ov < 3 * iv) ps[3] = 1'b1;
      end
      if ((flag & FLAG_TEST) != 0) ps[4] = 1'b1;
      if (flag == 0) ps[5] = 1'b1;
      r.ok        = 1'b1;
      r.in_volt   = vals[CODE_I];
      r.out_volt  = vals[CODE_O];
      r.load      = vals[CODE_L];
      r.charge    = vals[CODE_B];
      r.batt_volt = vals[CODE_V];
      r.temp      = vals[CODE_T][14:0];
      r.in_freq   = vals[CODE_F];
      r.out_freq  = vals[CODE_H];
      r.runtime   = vals[CODE_R];
      r.mask      = seen;
      r.pwr       = ps;
    end
    clear_parser();
    return r;
  endfunction

  function automatic void take_byte(logic [7:0] b, logic last);
    logic [7:0] lc;
    lc = b | CASE_BIT;
    if (at_start) begin
      at_start = 1'b0;
      hdr_ok   = (b == CH_HASH);
    end else if (hdr_ok) begin
      if (lc >= LC_A && lc <= LC_Z) begin
        close_field();
        open_field(b);
      end else begin
        feed_value(b);
      end
    end
    if (last) replies_due.push_back(finish_reply());
  endfunction

  task automatic report_error(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    status_result_t want;
    if (replies_due.size() == 0) begin
      report_error("result transfer with no reply outstanding");
      return;
    end
    want = replies_due.pop_front();
    check_field("parse_ok", 16'(parse_ok), 16'(want.ok));
    check_field("in_volt_tenths", in_volt_tenths, want.in_volt);
    check_field("out_volt_tenths", out_volt_tenths, want.out_volt);
    check_field("load_pct", load_pct, want.load);
    check_field("charge_pct", charge_pct, want.charge);
    check_field("batt_volt_tenths", batt_volt_tenths, want.batt_volt);
    check_field("temperature", {1'b0, temperature}, {1'b0, want.temp});
    check_field("in_freq_tenths", in_freq_tenths, want.in_freq);
    check_field("out_freq_tenths", out_freq_tenths, want.out_freq);
    check_field("runtime_min", runtime_min, want.runtime);
    check_field("present_mask", 16'(present_mask), 16'(want.mask));
    check_field("power_state", 16'(power_state), 16'(want.pwr));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_byte(rx_byte, end_of_reply);
    end
    errors  <= err_count;
    awaited <= replies_due.size();
  end

endmodule

// ===== tb/ups_status_reply_parser_tb.sv =====
// Testbench top: drives status replies into the parser and gives the verdict.
`timescale 1ns / 100ps
module ups_status_reply_parser_tb;
  import usrp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 1180;
  localparam int MIN_REPLIES  = 30;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = '0;
  logic              end_of_reply = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              parse_ok;
  logic [15:0]       in_volt_tenths;
  logic [15:0]       out_volt_tenths;
  logic [15:0]       load_pct;
  logic [15:0]       charge_pct;
  logic [15:0]       batt_volt_tenths;
  logic signed [14:0] temperature;
  logic [15:0]       in_freq_tenths;
  logic [15:0]       out_freq_tenths;
  logic [15:0]       runtime_min;
  logic [3:0]        present_mask;
  logic [5:0]        power_state;

  int chk_errors;
  int chk_awaited;

  // bytes of the reply being built, sent as one reply
  logic [7:0] reply_buf[$];
  int         burst_left   = 0;
  int         sent_bytes   = 0;
  int         sent_replies = 0;
  int         cycle_count  = 0;

  // mains voltages of the reply being built, in tenths; output tracks input
  // by a ratio picked near the power state band edges, plus 0.3 and 1.0
  int mains_in;
  int mains_out;
  int ratio_pct [16] = '{30, 49, 50, 51, 90, 94, 95, 96, 100, 104, 105, 106, 140, 149, 150, 151};

  // receiver stall pattern
  int   stall_mode = 0;
  int   mode_left  = 0;
  int   run_left   = 0;

  ups_status_reply_parser i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .end_of_reply     (end_of_reply),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parse_ok         (parse_ok),
    .in_volt_tenths   (in_volt_tenths),
    .out_volt_tenths  (out_volt_tenths),
    .load_pct         (load_pct),
    .charge_pct       (charge_pct),
    .batt_volt_tenths (batt_volt_tenths),
    .temperature      (temperature),
    .in_freq_tenths   (in_freq_tenths),
    .out_freq_tenths  (out_freq_tenths),
    .runtime_min      (runtime_min),
    .present_mask     (present_mask),
    .power_state      (power_state)
  );

  ups_reply_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .end_of_reply     (end_of_reply),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parse_ok         (parse_ok),
    .in_volt_tenths   (in_volt_tenths),
    .out_volt_tenths  (out_volt_tenths),
    .load_pct         (load_pct),
    .charge_pct       (charge_pct),
    .batt_volt_tenths (batt_volt_tenths),
    .temperature      (temperature),
    .in_freq_tenths   (in_freq_tenths),
    .out_freq_tenths  (out_freq_tenths),
    .runtime_min      (runtime_min),
    .present_mask     (present_mask),
    .power_state      (power_state),
    .errors           (chk_errors),
    .awaited          (chk_awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switch at random between stall patterns.
  // Mode 0 never stalls, 1 stalls lightly, 2 stalls half the time at random,
  // 3 holds stall on and off in long runs so the token queue fills up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
      run_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: begin
          if (run_left == 0) begin
            out_stall <= ~out_stall;
            run_left  <= $urandom_range(1, 40);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  // Sender: present one byte and hold it until the transfer. Work in bursts;
  // between bursts drop valid for a random gap, or none at all.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 20);
    end
    in_valid     <= 1'b1;
    rx_byte      <= b;
    end_of_reply <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    reply_buf.push_back(b);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
  endtask

  // Send the built reply; the last byte carries end_of_reply.
  task automatic send_reply();
    for (int i = 0; i < reply_buf.size(); i++) send_byte(reply_buf[i], i == reply_buf.size() - 1);
    reply_buf.delete();
    sent_replies++;
  endtask

  task automatic send_text(input string s);
    add_str(s);
    send_reply();
  endtask

  task automatic send_flagged(input string s, input logic [7:0] f);
    add_str(s);
    add_byte(f);
    send_reply();
  endtask

  function automatic logic is_letter(logic [7:0] b);
    logic [7:0] lc;
    lc = b | CASE_BIT;
    return (lc >= LC_A) && (lc <= LC_Z);
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (is_letter(b));
    return b;
  endfunction

  // letter that opens an unknown field: any lower case, or an unused upper case
  function automatic logic [7:0] other_letter();
    string spare;
    spare = "ACDEGJKMNPQUWXYZ";
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(LC_A, LC_Z));
    return spare[$urandom_range(0, 15)];
  endfunction

  function automatic logic [7:0] pick_code();
    string codes;
    int    k;
    codes = "IOLBVTFHRSF";
    k = $urandom_range(0, 11);
    if (k == 11) return other_letter();
    return codes[k];
  endfunction

  function automatic string tenths_text(int v);
    if (v % 10 == 0 && $urandom_range(0, 2) == 0) return $sformatf("%0d", v / 10);
    return $sformatf("%0d.%0d", v / 10, v % 10);
  endfunction

  function automatic string long_text();
    string s;
    s = "";
    repeat ($urandom_range(25, 40)) s = {s, " "};
    return {s, $sformatf("%0d", $urandom_range(1, 99))};
  endfunction

  function automatic string number_text();
    string edges[4];
    edges = '{"6553.5", "6553.6", "65535", "65536"};
    case ($urandom_range(0, 13))
      0, 1, 2: return $sformatf("%0d", $urandom_range(0, 999));
      3, 4:    return tenths_text($urandom_range(0, 9999));
      5:       return $sformatf(" \t%0d.%0d%0d", $urandom_range(0, 500),
                                $urandom_range(0, 9), $urandom_range(0, 9));
      6:       return $sformatf("%0d", $urandom_range(65530, 999999));
      7:       return $sformatf("-%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9));
      8:       return $sformatf("+%0d", $urandom_range(0, 999));
      9:       return $sformatf(".%0d", $urandom_range(0, 9));
      10:      return "";
      11:      return $sformatf("%0d%%/:%0d", $urandom_range(0, 99), $urandom_range(0, 9));
      12:      return long_text();
      default: return edges[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic string temp_text();
    case ($urandom_range(0, 5))
      0:       return $sformatf("%0d", $urandom_range(0, 60));
      1:       return $sformatf("-%0d", $urandom_range(0, 40));
      2:       return $sformatf("+%0d.%0d", $urandom_range(0, 80), $urandom_range(0, 9));
      3:       return $sformatf("-%0d", $urandom_range(9990, 99999));
      4:       return $sformatf("%0d", $urandom_range(9990, 99999));
      default: return " -0";
    endcase
  endfunction

  task automatic add_field(input logic [7:0] c);
    add_byte(c);
    case (c)
      "I": add_str(tenths_text(mains_in));
      "O": add_str(tenths_text(mains_out));
      "T": add_str(temp_text());
      "S": begin
        // flag byte first, then a little trailing junk; sometimes empty
        if ($urandom_range(0, 6) != 0) repeat ($urandom_range(1, 3)) add_byte(non_letter());
      end
      "L", "B", "V", "F", "H", "R": add_str(number_text());
      default: repeat ($urandom_range(0, 4)) add_byte(non_letter());
    endcase
  endtask

  // Build a reply of nf fields; a bad header swaps '#' for another byte.
  task automatic build_reply(input int nf, input logic good_header);
    int    r;
    int    first_b;
    r = $urandom_range(0, 9);
    if (r < 8) mains_in = $urandom_range(900, 2600);
    else if (r == 8) mains_in = $urandom_range(0, 20);
    else mains_in = $urandom_range(0, 65535);
    mains_out = mains_in * ratio_pct[$urandom_range(0, 15)] / 100
                + int'($urandom_range(0, 2)) - 1;
    if (mains_out < 0) mains_out = 0;
    if (good_header) begin
      add_byte(CH_HASH);
    end else begin
      do first_b = $urandom_range(0, 255); while (first_b == CH_HASH);
      add_byte(8'(first_b));
    end
    if (nf >= 2 && $urandom_range(0, 9) < 7) begin
      add_field("I");
      add_field("O");
      nf -= 2;
    end
    repeat (nf) add_field(pick_code());
    // a letter as the final byte opens a field that closes empty
    if ($urandom_range(0, 9) == 0) add_byte(pick_code());
  endtask

  initial begin
    int kind;
    int byte_base;
    int reply_base;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed replies ---
    // power state: no judgement on battery, then each band of output vs input
    send_text("#I2000O1000S@");
    send_text("#I2000O999.9S ");
    send_flagged("#I2000O1899.9S", 8'h01);
    send_flagged("#I2000O1900S", 8'h01);
    send_flagged("#I2000O2099.9S", 8'h01);
    send_flagged("#I2000O2100S", 8'h01);
    send_flagged("#I2000O2999.9S", 8'h01);
    send_flagged("#I2000O3000S", 8'h01);
    send_flagged("#I2300O2300L40S", FLAG_TEST);
    send_flagged("#I2300O2300L40S", 8'hFF);
    send_flagged("#I2300O2300L40S", 8'h00);
    send_text("#I1000O1200B90");
    // saturation and negative values
    send_text("#L99999I6553.5O6553.6V999999.9R65535F65535.9");
    send_text("#T-99999I-5L-3B-0R+8");
    send_text("#T99999O+1.99H-2.5V 12.34");
    // number syntax: whitespace, fraction without integer, double dot, lone sign
    add_str("#I ");
    add_byte(CH_TAB);
    send_text("12.34%5O.7L..5B+");
    // long values: the last accepted character, then one past it
    add_str("#R");
    repeat (30) add_byte(CH_ZERO);
    send_text("7L1B2");
    add_str("#R");
    repeat (31) add_byte(CH_ZERO);
    send_text("7L1B2");
    // empty values and a letter as the final byte
    send_text("#IOLB");
    // repeated fields; a second and third F land on the output frequency
    send_text("#L5L7L9F10F20F30.5");
    send_text("#x5y6i7I1O2L3");
    // bad header, lone bytes, too few fields
    send_text("I230O230L5B9");
    send_text("#");
    send_text("A");
    send_text("#I1O2");
    // field count past its ceiling
    add_byte(CH_HASH);
    repeat (70) add_str("L1");
    send_reply();
    // bytes with the top bit set
    add_str("#I12");
    add_byte(8'hFF);
    add_str("L3B4");
    add_byte(8'h80);
    add_str("S");
    add_byte(8'hC0);
    send_reply();

    // --- random replies ---
    // mostly well-formed replies with random content; the rest short,
    // headerless or plain noise
    byte_base  = sent_bytes;
    reply_base = sent_replies;
    while (sent_bytes - byte_base < RANDOM_BYTES || sent_replies - reply_base < MIN_REPLIES) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_reply($urandom_range(3, 10), 1'b1);
      end else if (kind < 80) begin
        build_reply($urandom_range(0, 2), 1'b1);
      end else if (kind < 88) begin
        build_reply($urandom_range(0, 6), 1'b0);
      end else if (kind < 96) begin
        add_byte(CH_HASH);
        repeat ($urandom_range(0, 40)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(($urandom_range(0, 1) == 0) ? CH_HASH : 8'($urandom_range(0, 255)));
      end
      send_reply();
    end
    in_valid <= 1'b0;

    // let the last expectation reach the checker, then drain
    @(posedge clk);
    while (chk_awaited != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (chk_errors == 0 && chk_awaited == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
